[rtl/core/lfpd_pkg.sv]
`timescale 1ns / 1ps
// Package for the line follower PD drive: field widths, register map, types and constants.
package lfpd_pkg;

   // field widths
   localparam int LEVEL_W = 7;
   localparam int COLOR_W = 10;
   localparam int GAIN_W  = 16;
   localparam int POWER_W = 8;
   localparam int ERR_W   = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // clip bound of both motor powers
   localparam int POWER_LIMIT = 100;

   // register map
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CRUISE_POWER = 3'd0,
      CSR_PROP_GAIN    = 3'd1,
      CSR_DERIV_GAIN   = 3'd2,
      CSR_DARK_TARGET  = 3'd3,
      CSR_LIGHT_TARGET = 3'd4,
      CSR_RED_LIMIT    = 3'd5,
      CSR_GREEN_LIMIT  = 3'd6,
      CSR_BLUE_LIMIT   = 3'd7
   } csr_index_type;

   // register reset values
   localparam logic [LEVEL_W-1:0] CRUISE_POWER_RST = 7'd50;
   localparam logic [GAIN_W-1:0]  PROP_GAIN_RST    = 16'd282;
   localparam logic [GAIN_W-1:0]  DERIV_GAIN_RST   = 16'd5;
   localparam logic [LEVEL_W-1:0] DARK_TARGET_RST  = 7'd15;
   localparam logic [LEVEL_W-1:0] LIGHT_TARGET_RST = 7'd39;
   localparam logic [COLOR_W-1:0] RED_LIMIT_RST    = 10'd20;
   localparam logic [COLOR_W-1:0] GREEN_LIMIT_RST  = 10'd48;
   localparam logic [COLOR_W-1:0] BLUE_LIMIT_RST   = 10'd85;

   typedef struct packed {
      logic [LEVEL_W-1:0] cruise_power;
      logic [GAIN_W-1:0]  prop_gain;
      logic [GAIN_W-1:0]  deriv_gain;
      logic [LEVEL_W-1:0] dark_target;
      logic [LEVEL_W-1:0] light_target;
      logic [COLOR_W-1:0] red_limit;
      logic [COLOR_W-1:0] green_limit;
      logic [COLOR_W-1:0] blue_limit;
   } cfg_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] light_level;
      logic [COLOR_W-1:0] red_raw;
      logic [COLOR_W-1:0] green_raw;
      logic [COLOR_W-1:0] blue_raw;
   } sample_type;

   typedef struct packed {
      logic signed [POWER_W-1:0] left_power;
      logic signed [POWER_W-1:0] right_power;
   } drive_type;

endpackage

[rtl/core/lfpd_if.sv]
`timescale 1ns / 1ps
// Request and response channel interfaces of the line follower PD drive.
interface lfpd_req_if;
   import lfpd_pkg::*;

   logic               valid;
   logic               ready;
   logic [LEVEL_W-1:0] light_level;
   logic [COLOR_W-1:0] red_raw;
   logic [COLOR_W-1:0] green_raw;
   logic [COLOR_W-1:0] blue_raw;

   modport source (output valid, output light_level, output red_raw, output green_raw,
                   output blue_raw, input ready);
   modport sink (input valid, input light_level, input red_raw, input green_raw,
                 input blue_raw, output ready);
endinterface

interface lfpd_rsp_if;
   import lfpd_pkg::*;

   logic                      valid;
   logic                      ready;
   logic signed [POWER_W-1:0] left_power;
   logic signed [POWER_W-1:0] right_power;

   modport source (output valid, output left_power, output right_power, input ready);
   modport sink (input valid, input left_power, input right_power, output ready);
endinterface

[rtl/core/lfpd_cfg_regs.sv]
`timescale 1ns / 1ps
// Configuration register file of the line follower PD drive.
module lfpd_cfg_regs (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [lfpd_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [lfpd_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output lfpd_pkg::cfg_type                 cfg
);
   import lfpd_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // decode the write and update the addressed register
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_CRUISE_POWER: cfg_in.cruise_power = csr_wdata[LEVEL_W-1:0];
            CSR_PROP_GAIN:    cfg_in.prop_gain    = csr_wdata[GAIN_W-1:0];
            CSR_DERIV_GAIN:   cfg_in.deriv_gain   = csr_wdata[GAIN_W-1:0];
            CSR_DARK_TARGET:  cfg_in.dark_target  = csr_wdata[LEVEL_W-1:0];
            CSR_LIGHT_TARGET: cfg_in.light_target = csr_wdata[LEVEL_W-1:0];
            CSR_RED_LIMIT:    cfg_in.red_limit    = csr_wdata[COLOR_W-1:0];
            CSR_GREEN_LIMIT:  cfg_in.green_limit  = csr_wdata[COLOR_W-1:0];
            CSR_BLUE_LIMIT:   cfg_in.blue_limit   = csr_wdata[COLOR_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cruise_power <= CRUISE_POWER_RST;
         cfg_ff.prop_gain    <= PROP_GAIN_RST;
         cfg_ff.deriv_gain   <= DERIV_GAIN_RST;
         cfg_ff.dark_target  <= DARK_TARGET_RST;
         cfg_ff.light_target <= LIGHT_TARGET_RST;
         cfg_ff.red_limit    <= RED_LIMIT_RST;
         cfg_ff.green_limit  <= GREEN_LIMIT_RST;
         cfg_ff.blue_limit   <= BLUE_LIMIT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[rtl/core/lfpd_ctrl_law.sv]
`timescale 1ns / 1ps
// PD control law: target select, error, gain products, truncation and power clipping.
module lfpd_ctrl_law (
   input  lfpd_pkg::cfg_type                      cfg,
   input  lfpd_pkg::sample_type                   sample,
   input  logic signed [lfpd_pkg::ERR_W-1:0]      prev_err,
   output logic signed [lfpd_pkg::ERR_W-1:0]      err,
   output lfpd_pkg::drive_type                    drive
);
   import lfpd_pkg::*;

   localparam int SUM_W  = 26;
   localparam int CORR_W = SUM_W - 8;
   localparam int PWR_W  = CORR_W + 1;
   localparam logic signed [PWR_W-1:0] PWR_HI = PWR_W'(POWER_LIMIT);
   localparam logic signed [PWR_W-1:0] PWR_LO = -PWR_W'(POWER_LIMIT);

   logic                      dark;
   logic [LEVEL_W-1:0]        target;
   logic signed [SUM_W-1:0]   kp_s;
   logic signed [SUM_W-1:0]   kd_s;
   logic signed [SUM_W-1:0]   err_s;
   logic signed [SUM_W-1:0]   delta_s;
   logic signed [SUM_W-1:0]   p_term;
   logic signed [SUM_W-1:0]   d_term;
   logic signed [SUM_W-1:0]   sum;
   logic [SUM_W-1:0]          sum_mag;
   logic [CORR_W-1:0]         corr_mag;
   logic signed [PWR_W-1:0]   corr;
   logic signed [PWR_W-1:0]   base_s;
   logic signed [PWR_W-1:0]   left_raw;
   logic signed [PWR_W-1:0]   right_raw;

   // clip a wide power to the motor range
   function automatic logic signed [POWER_W-1:0] clip_power(input logic signed [PWR_W-1:0] v);
      logic signed [POWER_W-1:0] r;
      if (v > PWR_HI) begin
         r = POWER_W'(POWER_LIMIT);
      end else if (v < PWR_LO) begin
         r = -POWER_W'(POWER_LIMIT);
      end else begin
         r = v[POWER_W-1:0];
      end
      return r;
   endfunction

   // pick the target from the color thresholds
   assign dark   = (sample.red_raw <= cfg.red_limit) && (sample.green_raw <= cfg.green_limit)
                   && (sample.blue_raw <= cfg.blue_limit);
   assign target = dark ? cfg.dark_target : cfg.light_target;
   assign err    = $signed({1'b0, target}) - $signed({1'b0, sample.light_level});

   // proportional and derivative terms at full precision
   assign kp_s    = $signed({{(SUM_W-GAIN_W){1'b0}}, cfg.prop_gain});
   assign kd_s    = $signed({{(SUM_W-GAIN_W){1'b0}}, cfg.deriv_gain});
   assign err_s   = SUM_W'(err);
   assign delta_s = SUM_W'(err) - SUM_W'(prev_err);
   assign p_term  = kp_s * err_s;
   assign d_term  = kd_s * delta_s;
   assign sum     = p_term + d_term;

   // drop the Q8.8 fraction, rounding toward zero
   assign sum_mag  = sum[SUM_W-1] ? SUM_W'(-sum) : sum;
   assign corr_mag = sum_mag[SUM_W-1:8];
   assign corr     = sum[SUM_W-1] ? -$signed({1'b0, corr_mag}) : $signed({1'b0, corr_mag});

   // steer: slow one side, speed up the other
   assign base_s    = $signed({{(PWR_W-LEVEL_W){1'b0}}, cfg.cruise_power});
   assign left_raw  = base_s - corr;
   assign right_raw = base_s + corr;

   assign drive.left_power  = clip_power(left_raw);
   assign drive.right_power = clip_power(right_raw);

endmodule

[rtl/core/line_follow_pd_drive.sv]
`timescale 1ns / 1ps
// Top level of the line follower PD drive: request register, control law, response register.
//
// Usage:
//   Each request on req_chan carries one sensor sample (light level and raw red, green
//   and blue). Each sample gives exactly one response on rsp_chan with the left and
//   right motor powers, clipped to -100..100, in request order.
//   A request is taken at a rising edge with valid and ready high; that edge loads the
//   request register, and the sample moves into the response register at an edge where
//   that register is free. Throughput is one request per cycle while rsp_chan.ready is
//   high; the control law between the two registers is combinational.
//   The derivative term uses the error of the previous sample, kept in a register
//   that advances as each sample moves into the response register.
//   csr_we/csr_index/csr_wdata write the eight gain, speed, target and threshold
//   registers; write them only while no sample is in flight.
//   Reset (synchronous, active high) empties both stages, clears the previous error
//   and loads the default register values.
//   When rsp_chan.ready is low the response holds; the request register still takes
//   one more sample, and req_chan.ready falls once both stages are full.
module line_follow_pd_drive (
   input  logic                            clock,
   input  logic                            reset,
   lfpd_req_if.sink                        req_chan,
   lfpd_rsp_if.source                      rsp_chan,
   input  logic                            csr_we,
   input  logic [lfpd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [lfpd_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import lfpd_pkg::*;

   cfg_type                   cfg;
   logic                      req_valid_ff;
   logic                      req_valid_in;
   sample_type                sample_ff;
   sample_type                sample_in;
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   drive_type                 drive_ff;
   drive_type                 drive_in;
   logic signed [ERR_W-1:0]   prev_err_ff;
   logic signed [ERR_W-1:0]   prev_err_in;
   logic signed [ERR_W-1:0]   err;
   drive_type                 drive;
   logic                      rsp_free;
   logic                      req_free;
   logic                      req_take;
   logic                      advance;

   lfpd_cfg_regs u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   lfpd_ctrl_law u_law (
      .cfg      (cfg),
      .sample   (sample_ff),
      .prev_err (prev_err_ff),
      .err      (err),
      .drive    (drive)
   );

   // stage handshakes
   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;
   assign req_free = !req_valid_ff || rsp_free;
   assign advance  = req_valid_ff && rsp_free;
   assign req_take = req_chan.valid && req_free;

   assign req_chan.ready = req_free;

   // next state of both stages
   always_comb begin
      req_valid_in = req_valid_ff;
      if (req_take) begin
         req_valid_in = 1'b1;
      end else if (advance) begin
         req_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      sample_in = sample_ff;
      if (req_take) begin
         sample_in.light_level = req_chan.light_level;
         sample_in.red_raw     = req_chan.red_raw;
         sample_in.green_raw   = req_chan.green_raw;
         sample_in.blue_raw    = req_chan.blue_raw;
      end

      drive_in    = advance ? drive : drive_ff;
      prev_err_in = advance ? err : prev_err_ff;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         prev_err_ff  <= '0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         prev_err_ff  <= prev_err_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      sample_ff <= sample_in;
      drive_ff  <= drive_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.left_power  = drive_ff.left_power;
   assign rsp_chan.right_power = drive_ff.right_power;

   // a stalled sample stays in the request register
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid_ff && !rsp_free |=> req_valid_ff)
      else $error("request register lost a stalled sample");

   // a taken request is present in the request register next cycle
   a_req_load: assert property (@(posedge clock) disable iff (reset)
      req_take |=> req_valid_ff)
      else $error("taken request did not load");

   // a sample reaching the response register raises its valid
   a_rsp_load: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("advanced sample missing from response register");

   // powers stay inside the motor range
   a_power_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (drive_ff.left_power <= POWER_W'(POWER_LIMIT))
                    && (drive_ff.left_power >= -POWER_W'(POWER_LIMIT))
                    && (drive_ff.right_power <= POWER_W'(POWER_LIMIT))
                    && (drive_ff.right_power >= -POWER_W'(POWER_LIMIT)))
      else $error("motor power out of range");

   // previous error changes only when a sample advances
   a_err_stable: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(prev_err_ff))
      else $error("previous error moved without a sample");

endmodule
